### src/rau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants of the rational arithmetic unit.
// Used by rau_gcd, rau_div and rational_arithmetic_unit; depends on nothing.
package rau_pkg;

  // Default operand width and the fixed widths of the internal datapath.
  localparam int unsigned OperandWidthDef = 32;
  localparam int unsigned MAG_W  = 32;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned DEN_W  = 63;
  localparam int unsigned SHIFT_W = $clog2(WORD_W);

  // Command codes.
  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_CMP = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [1:0] ST_ZERO_DEN = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // Handshake between the sequencer and a multi-cycle unit.
  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage
`default_nettype wire

### src/rau_gcd.sv
`timescale 1ns / 1ps
`default_nettype none
// Binary GCD unit: one compare, subtract or shift step per cycle.
// Depends on rau_pkg. Both operands must be nonzero.
module rau_gcd
  import rau_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire unit_req_t         req_i,
  input  wire logic [WORD_W-1:0] a_i,
  input  wire logic [WORD_W-1:0] b_i,
  output unit_stat_t             stat_o,
  output logic [WORD_W-1:0]      g_o
);

  logic [WORD_W-1:0]  a_q, a_d, b_q, b_d, g_q, g_d;
  logic [SHIFT_W-1:0] k_q, k_d;
  logic               busy_q, busy_d, done_q, done_d;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    k_d    = k_q;
    g_d    = g_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      a_d    = a_i;
      b_d    = b_i;
      k_d    = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!a_q[0] && !b_q[0]) begin
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + 1'b1;
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (a_q == b_q) begin
        g_d    = a_q << k_q;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else if (a_q > b_q) begin
        a_d = a_q - b_q;
      end else begin
        b_d = b_q - a_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      a_q    <= a_d;
      b_q    <= b_d;
      k_q    <= k_d;
      g_q    <= g_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign g_o         = g_q;

endmodule
`default_nettype wire

### src/rau_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle.
// Depends on rau_pkg. The divisor must be nonzero.
module rau_div
  import rau_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire unit_req_t         req_i,
  input  wire logic [WORD_W-1:0] dividend_i,
  input  wire logic [WORD_W-1:0] divisor_i,
  output unit_stat_t             stat_o,
  output logic [WORD_W-1:0]      quo_o
);

  localparam int unsigned CNT_W = $clog2(WORD_W + 1);

  logic [WORD_W-1:0] rem_q, rem_d, quo_q, quo_d, dsr_q, dsr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [WORD_W:0]   rem_sh;
  logic [WORD_W+1:0] diff;

  always_comb begin
    rem_sh = {rem_q, quo_q[WORD_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dsr_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
      cnt_d  = CNT_W'(WORD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[WORD_W+1]) begin
        rem_d = diff[WORD_W-1:0];
        quo_d = {quo_q[WORD_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[WORD_W-1:0];
        quo_d = {quo_q[WORD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      dsr_q  <= dsr_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

endmodule
`default_nettype wire

### src/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Rational arithmetic unit: add, subtract, multiply, divide and compare of two fractions,
// with the result reduced by its GCD. Depends on rau_pkg, rau_gcd and rau_div.
//
//  Channel   Direction  Handshake                     Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata operands, tuser command
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata result and flags, tuser status
//
// An arithmetic transaction runs a setup (up to three products on one 32x32 multiplier
// and a combine step), then binary GCD steps, then two passes through the bit-serial
// divider. Compare transactions and zero results stop after the combine step; error
// transactions go from idle straight to S_FIN. The GCD loop and the divider set the
// rate. Reset is asynchronous and active low and empties the block. A finished result
// waits in the output register while the next transaction is taken and worked.
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = OperandWidthDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // left_numer[31:0], left_denom[63:32], right_numer[95:64], right_denom[127:96]
  input  wire logic [127:0] s_axis_tdata,
  // command[2:0]
  input  wire logic [2:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // result_numer[63:0], result_denom[126:64], is_less[127], is_equal[128], zeros above
  output logic [135:0]      m_axis_tdata,
  // status[1:0]
  output logic [1:0]        m_axis_tuser
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_COMB, S_GCD_GO, S_GCD,
    S_DIVN_GO, S_DIVN, S_DIVD_GO, S_DIVD, S_FIN
  } state_e;

  state_e state_q;

  // Operand magnitude from the low OPERAND_WIDTH bits of a field; the sign is its top bit.
  function automatic logic [MAG_W-1:0] mag_f(input logic [31:0] raw);
    logic [OPERAND_WIDTH-1:0] v;
    logic [OPERAND_WIDTH-1:0] m;
    v = raw[OPERAND_WIDTH-1:0];
    m = v[OPERAND_WIDTH-1] ? (~v + 1'b1) : v;
    return MAG_W'(m);
  endfunction

  logic [MAG_W-1:0] in_lnm, in_ldm, in_rnm, in_rdm;
  logic [MAG_W-1:0] lnm_q, ldm_q, rnm_q, rdm_q;
  logic             lnn_q, ldn_q, rnn_q, rdn_q;
  logic [2:0]       cmd_q;

  assign in_lnm = mag_f(s_axis_tdata[31:0]);
  assign in_ldm = mag_f(s_axis_tdata[63:32]);
  assign in_rnm = mag_f(s_axis_tdata[95:64]);
  assign in_rdm = mag_f(s_axis_tdata[127:96]);

  // The single multiplier, fed by the sequencer one product per cycle.
  logic [MAG_W-1:0]  mul_a, mul_b;
  logic [WORD_W-1:0] mul_p;
  logic [WORD_W-1:0] p1_q, p2_q, p3_q;

  always_comb begin
    case (state_q)
      S_MUL1: begin
        mul_a = lnm_q;
        mul_b = (cmd_q == CMD_MUL) ? rnm_q : rdm_q;
      end
      S_MUL2: begin
        mul_a = ldm_q;
        mul_b = (cmd_q == CMD_MUL) ? rdm_q : rnm_q;
      end
      default: begin
        mul_a = ldm_q;
        mul_b = rdm_q;
      end
    endcase
  end

  assign mul_p = WORD_W'(mul_a) * WORD_W'(mul_b);

  // Combine step: signed sum for add/subtract, sign selection, and compare.
  logic              n1, n2, sum_neg, nn, nd;
  logic [WORD_W-1:0] sum_mag, mn_c, md_c;
  logic signed [WORD_W:0] cmp_a, cmp_b;

  always_comb begin
    n1 = (lnn_q ^ rdn_q) & (p1_q != '0);
    n2 = ((ldn_q ^ rnn_q) & (p2_q != '0)) ^ (cmd_q == CMD_SUB);
    if (n1 == n2) begin
      sum_neg = n1;
      sum_mag = p1_q + p2_q;
    end else if (p1_q >= p2_q) begin
      sum_neg = n1;
      sum_mag = p1_q - p2_q;
    end else begin
      sum_neg = n2;
      sum_mag = p2_q - p1_q;
    end
    case (cmd_q)
      CMD_MUL: begin
        nn   = lnn_q ^ rnn_q;
        mn_c = p1_q;
        nd   = ldn_q ^ rdn_q;
        md_c = p2_q;
      end
      CMD_DIV: begin
        nn   = lnn_q ^ rdn_q;
        mn_c = p1_q;
        nd   = ldn_q ^ rnn_q;
        md_c = p2_q;
      end
      default: begin
        nn   = sum_neg;
        mn_c = sum_mag;
        nd   = ldn_q ^ rdn_q;
        md_c = p3_q;
      end
    endcase
    // For compare both sides get a positive denominator first.
    cmp_a = (lnn_q ^ ldn_q) ? -$signed({1'b0, p1_q}) : $signed({1'b0, p1_q});
    cmp_b = (rnn_q ^ rdn_q) ? -$signed({1'b0, p2_q}) : $signed({1'b0, p2_q});
  end

  // Shared GCD and divider units.
  unit_req_t         gcd_req, div_req;
  unit_stat_t        gcd_stat, div_stat;
  logic [WORD_W-1:0] gcd_g, div_quo, div_dividend;
  logic [WORD_W-1:0] mn_q, md_q, g_q;
  logic              neg_q;

  assign gcd_req.start = (state_q == S_GCD_GO);
  assign div_req.start = (state_q == S_DIVN_GO) || (state_q == S_DIVD_GO);
  assign div_dividend  = (state_q == S_DIVN_GO) ? mn_q : md_q;

  rau_gcd u_gcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (gcd_req),
    .a_i    (mn_q),
    .b_i    (md_q),
    .stat_o (gcd_stat),
    .g_o    (gcd_g)
  );

  rau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .divisor_i  (g_q),
    .stat_o     (div_stat),
    .quo_o      (div_quo)
  );

  // Pending result and the output register.
  logic [WORD_W-1:0] res_numer_q, out_numer_q;
  logic [DEN_W-1:0]  res_denom_q, out_denom_q;
  logic              res_less_q, res_equal_q, out_less_q, out_equal_q;
  logic [1:0]        res_status_q, out_status_q;
  logic              out_valid_q;
  logic              in_fire;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // In S_FIN the output register is refilled instead of emptied.
      if (out_valid_q && m_axis_tready && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            cmd_q <= s_axis_tuser;
            lnm_q <= in_lnm;
            ldm_q <= in_ldm;
            rnm_q <= in_rnm;
            rdm_q <= in_rdm;
            lnn_q <= s_axis_tdata[OPERAND_WIDTH-1];
            ldn_q <= s_axis_tdata[32+OPERAND_WIDTH-1];
            rnn_q <= s_axis_tdata[64+OPERAND_WIDTH-1];
            rdn_q <= s_axis_tdata[96+OPERAND_WIDTH-1];
            res_less_q  <= 1'b0;
            res_equal_q <= 1'b0;
            if (s_axis_tuser > CMD_CMP) begin
              res_numer_q  <= '0;
              res_denom_q  <= DEN_W'(1);
              res_status_q <= ST_OK;
              state_q      <= S_FIN;
            end else if (in_ldm == '0 || in_rdm == '0) begin
              res_numer_q  <= '0;
              res_denom_q  <= '0;
              res_status_q <= ST_ZERO_DEN;
              state_q      <= S_FIN;
            end else if (s_axis_tuser == CMD_DIV && in_rnm == '0) begin
              res_numer_q  <= '0;
              res_denom_q  <= '0;
              res_status_q <= ST_DIV_ZERO;
              state_q      <= S_FIN;
            end else begin
              state_q <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          p1_q    <= mul_p;
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          p2_q    <= mul_p;
          state_q <= (cmd_q == CMD_ADD || cmd_q == CMD_SUB) ? S_MUL3 : S_COMB;
        end
        S_MUL3: begin
          p3_q    <= mul_p;
          state_q <= S_COMB;
        end
        S_COMB: begin
          mn_q  <= mn_c;
          md_q  <= md_c;
          neg_q <= nn ^ nd;
          if (cmd_q == CMD_CMP) begin
            res_numer_q  <= '0;
            res_denom_q  <= DEN_W'(1);
            res_less_q   <= (cmp_a < cmp_b);
            res_equal_q  <= (cmp_a == cmp_b);
            res_status_q <= ST_OK;
            state_q      <= S_FIN;
          end else if (mn_c == '0) begin
            res_numer_q  <= '0;
            res_denom_q  <= DEN_W'(1);
            res_status_q <= ST_OK;
            state_q      <= S_FIN;
          end else begin
            state_q <= S_GCD_GO;
          end
        end
        S_GCD_GO: begin
          state_q <= S_GCD;
        end
        S_GCD: begin
          if (gcd_stat.done) begin
            g_q     <= gcd_g;
            state_q <= S_DIVN_GO;
          end
        end
        S_DIVN_GO: begin
          state_q <= S_DIVN;
        end
        S_DIVN: begin
          if (div_stat.done) begin
            mn_q    <= div_quo;
            state_q <= S_DIVD_GO;
          end
        end
        S_DIVD_GO: begin
          state_q <= S_DIVD;
        end
        S_DIVD: begin
          if (div_stat.done) begin
            // A positive magnitude of 2^63 is the one value that cannot be stored.
            if (neg_q) begin
              res_numer_q  <= ~mn_q + 1'b1;
              res_denom_q  <= div_quo[DEN_W-1:0];
              res_status_q <= ST_OK;
            end else if (mn_q[WORD_W-1]) begin
              res_numer_q  <= '0;
              res_denom_q  <= '0;
              res_status_q <= ST_OVERFLOW;
            end else begin
              res_numer_q  <= mn_q;
              res_denom_q  <= div_quo[DEN_W-1:0];
              res_status_q <= ST_OK;
            end
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_q || m_axis_tready) begin
            out_numer_q  <= res_numer_q;
            out_denom_q  <= res_denom_q;
            out_less_q   <= res_less_q;
            out_equal_q  <= res_equal_q;
            out_status_q <= res_status_q;
            out_valid_q  <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_equal_q, out_less_q, out_denom_q, out_numer_q};
  assign m_axis_tuser  = out_status_q;

`ifndef SYNTH
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a transaction is in progress");

  a_error_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ST_ZERO_DEN || m_axis_tuser == ST_DIV_ZERO))
    |-> (out_numer_q == '0 && out_denom_q == '0))
    else $error("error result is not 0/0");

  a_ok_denom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_OK) |-> (out_denom_q != '0))
    else $error("ok result with zero denominator");

  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gcd_stat.done |-> (gcd_g != '0))
    else $error("gcd unit returned zero");
`endif

endmodule
`default_nettype wire
